FILE: rtl/deq_pkg.sv
// Shared opcode, status codes and result word type for the deque unit.
`default_nettype none
package deq_pkg;

	localparam int OP_W = 3;
	localparam int ST_W = 2;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_LIST       = 3'd4;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_ITEM  = 2'd3;

	// result word control from the sequencer to the output stage
	typedef struct packed {
		logic            stat_v;
		logic [ST_W-1:0] status;
		logic            item_v;
		logic            item_last;
	} res_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/deq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/deq_ctl.sv
// Deque sequencer: front pointer, count, RAM addressing and listing walk.
`default_nettype none
module deq_ctl #(
	parameter int CAPACITY = 16,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [deq_pkg::OP_W-1:0] opcode,
	output logic                         busy,
	output logic                         we,
	output logic      [AW-1:0]           waddr,
	output logic                         re,
	output logic      [AW-1:0]           raddr,
	output deq_pkg::res_ctl_t            res,
	output logic      [CW-1:0]           occupancy
);

	localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
	localparam logic [AW:0]   CAP_EXT  = (AW + 1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);

	logic [AW-1:0] front_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rem_q;
	logic [AW-1:0] rptr_q;
	logic          stat_v_q;
	logic [deq_pkg::ST_W-1:0] status_q;
	logic          item_v_s1;
	logic          item_last_s1;

	logic          acc;
	logic          full;
	logic          empty;
	logic [AW:0]   bsum;
	logic [AW-1:0] back_idx;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic [AW-1:0] raddr_inc;
	logic          list_go;
	logic          stat_go;

	assign busy  = rem_q != '0;
	assign acc   = start & ~busy;
	assign full  = cnt_q == CAP_CNT;
	assign empty = cnt_q == '0;

	assign bsum      = {1'b0, front_q} + (AW + 1)'(cnt_q);
	assign back_idx  = (bsum >= CAP_EXT) ? AW'(bsum - CAP_EXT) : AW'(bsum);
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + AW'(1);

	assign we    = acc & ~full & (opcode inside {deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK});
	assign waddr = (opcode == deq_pkg::OP_PUSH_FRONT) ? front_dec : back_idx;

	assign list_go   = acc & (opcode == deq_pkg::OP_LIST) & ~empty;
	assign re        = list_go | busy;
	assign raddr     = busy ? rptr_q : front_q;
	assign raddr_inc = (raddr == LAST_IDX) ? '0 : raddr + AW'(1);

	assign stat_go = acc & ((opcode inside {deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK,
		deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK}) | ((opcode == deq_pkg::OP_LIST) & empty));

	assign res.stat_v    = stat_v_q;
	assign res.status    = status_q;
	assign res.item_v    = item_v_s1;
	assign res.item_last = item_last_s1;
	assign occupancy     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q      <= '0;
			cnt_q        <= '0;
			rem_q        <= '0;
			rptr_q       <= '0;
			stat_v_q     <= 1'b0;
			status_q     <= deq_pkg::ST_OK;
			item_v_s1    <= 1'b0;
			item_last_s1 <= 1'b0;
		end else begin
			stat_v_q  <= stat_go;
			item_v_s1 <= re;
			if (re) begin
				rptr_q       <= raddr_inc;
				item_last_s1 <= busy ? (rem_q == ONE_CNT) : (cnt_q == ONE_CNT);
			end
			if (busy) begin
				rem_q <= rem_q - ONE_CNT;
			end
			if (acc) begin
				case (opcode)
					deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
						if (full) begin
							status_q <= deq_pkg::ST_FULL;
						end else begin
							status_q <= deq_pkg::ST_OK;
							cnt_q    <= cnt_q + ONE_CNT;
							if (opcode == deq_pkg::OP_PUSH_FRONT) begin
								front_q <= front_dec;
							end
						end
					end
					deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
						if (empty) begin
							status_q <= deq_pkg::ST_EMPTY;
						end else begin
							status_q <= deq_pkg::ST_OK;
							cnt_q    <= cnt_q - ONE_CNT;
							if (opcode == deq_pkg::OP_POP_FRONT) begin
								front_q <= front_inc;
							end
						end
					end
					deq_pkg::OP_LIST: begin
						if (empty) begin
							status_q <= deq_pkg::ST_EMPTY;
						end else begin
							rem_q <= cnt_q - ONE_CNT;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/double_ended_queue_unit.sv
// Top level of the bounded deque: ring RAM, sequencer and result word mux.
//
//  channel  | handshake            | words
//  ---------+----------------------+-------------------------------------------
//  command  | start / busy         | opcode, value
//  result   | strobe (no backpress)| status, element, is_last, occupancy
//
// Insert and delete each give one status word, which shows the cycle after
// the command is taken, and a new command may follow every cycle.
// A listing of N elements reads the RAM once per cycle and holds busy while it
// reads the last N-1; words show from the cycle after the command, one per cycle.
// Reset clears pointer and count at once; RAM contents are not cleared.
// Results cannot be stalled; every word is valid for exactly one cycle.
`default_nettype none
module double_ended_queue_unit #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [deq_pkg::OP_W-1:0]      opcode,
	input  wire logic signed [DATA_WIDTH-1:0]  value,
	output logic                               strobe,
	output logic      [deq_pkg::ST_W-1:0]      status,
	output logic signed [DATA_WIDTH-1:0]       element,
	output logic                               is_last,
	output logic      [CW-1:0]                 occupancy
);

	logic              we;
	logic [AW-1:0]     waddr;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [DATA_WIDTH-1:0] rdata;
	deq_pkg::res_ctl_t res;

	deq_ctl #(.CAPACITY(CAPACITY)) u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.opcode    (opcode),
		.busy      (busy),
		.we        (we),
		.waddr     (waddr),
		.re        (re),
		.raddr     (raddr),
		.res       (res),
		.occupancy (occupancy)
	);

	deq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		strobe = res.stat_v | res.item_v;
		if (res.item_v) begin
			status  = deq_pkg::ST_ITEM;
			element = rdata;
			is_last = res.item_last;
		end else begin
			status  = res.status;
			element = '0;
			is_last = 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/deq_chk.sv
// Port-level checker for the deque unit and its bind to the top level.
`default_nettype none
module deq_chk #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic [deq_pkg::OP_W-1:0]      opcode,
	input wire logic                          strobe,
	input wire logic [deq_pkg::ST_W-1:0]      status,
	input wire logic signed [DATA_WIDTH-1:0]  element,
	input wire logic                          is_last,
	input wire logic [CW-1:0]                 occupancy
);

	logic acc;
	assign acc = start & ~busy;

	a_known_op_answers: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (opcode <= deq_pkg::OP_LIST) |=> strobe)
		else $error("no word after a command");

	a_unknown_op_silent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (opcode > deq_pkg::OP_LIST) |=> !strobe)
		else $error("word after an unused opcode");

	a_status_word_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status != deq_pkg::ST_ITEM) |-> is_last && (element == '0))
		else $error("status word not final or element not zero");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == deq_pkg::ST_FULL) |-> occupancy == CW'(CAPACITY))
		else $error("full reported below capacity");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == deq_pkg::ST_EMPTY) |-> occupancy == '0)
		else $error("empty reported with elements stored");

endmodule

bind double_ended_queue_unit deq_chk #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.opcode    (opcode),
	.strobe    (strobe),
	.status    (status),
	.element   (element),
	.is_last   (is_last),
	.occupancy (occupancy)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for double_ended_queue_unit: directed table, then random traffic against a ring model.
`default_nettype none
module tb_top;
	import deq_pkg::*;

	localparam int CAP        = 16;
	localparam int DW         = 32;
	localparam int RAND_ITEMS = 120;
	localparam int CALM_TAIL  = 40;
	localparam int DIR_ROWS   = 25;

	localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

	typedef struct packed {
		logic [ST_W-1:0]      status;
		logic signed [DW-1:0] element;
		logic                 is_last;
		logic [4:0]           occupancy;
	} deq_word_t;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic signed [DW-1:0] val;
		logic [4:0]           rep;
		logic                 pinned;
		deq_word_t            word;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [OP_W-1:0]      opcode = OP_PUSH_FRONT;
	logic signed [DW-1:0] value = '0;
	logic                 busy;
	logic                 strobe;
	logic [ST_W-1:0]      status;
	logic signed [DW-1:0] element;
	logic                 is_last;
	logic [4:0]           occupancy;

	// pinned expectation travelling with the current word
	logic      pin_valid = 1'b0;
	deq_word_t pin_word = '0;

	logic signed [DW-1:0] ring_mem [CAP];
	logic [3:0]           ring_head = '0;
	logic [4:0]           ring_count = '0;
	deq_word_t            pending_words [$];
	int                   mismatch_count = 0;

	dir_row_t dir_tab [DIR_ROWS] = '{
		'{OP_LIST,       32'sh00000000, 5'd1,  1'b1, '{ST_EMPTY, 32'sd0, 1'b1, 5'd0}},
		'{OP_POP_FRONT,  32'sh00000000, 5'd1,  1'b1, '{ST_EMPTY, 32'sd0, 1'b1, 5'd0}},
		'{OP_POP_BACK,   32'sh00000000, 5'd1,  1'b1, '{ST_EMPTY, 32'sd0, 1'b1, 5'd0}},
		'{OP_PUSH_BACK,  32'sh7fffffff, 5'd1,  1'b1, '{ST_OK,    32'sd0, 1'b1, 5'd1}},
		'{OP_PUSH_FRONT, 32'sh80000000, 5'd1,  1'b1, '{ST_OK,    32'sd0, 1'b1, 5'd2}},
		'{OP_PUSH_BACK,  32'shffffffff, 5'd1,  1'b1, '{ST_OK,    32'sd0, 1'b1, 5'd3}},
		'{OP_PUSH_FRONT, 32'sh00000000, 5'd1,  1'b1, '{ST_OK,    32'sd0, 1'b1, 5'd4}},
		'{OP_LIST,       32'sh00000000, 5'd1,  1'b0, '0},
		'{OP_RSVD_5,     32'shffffffff, 5'd1,  1'b0, '0},
		'{OP_RSVD_6,     32'sh12345678, 5'd1,  1'b0, '0},
		'{OP_RSVD_7,     32'shffffffff, 5'd1,  1'b0, '0},
		'{OP_POP_FRONT,  32'shffffffff, 5'd1,  1'b1, '{ST_OK,    32'sd0, 1'b1, 5'd3}},
		'{OP_POP_BACK,   32'sh00000000, 5'd1,  1'b1, '{ST_OK,    32'sd0, 1'b1, 5'd2}},
		'{OP_LIST,       32'sh00000000, 5'd1,  1'b0, '0},
		'{OP_PUSH_BACK,  32'sha5a5a5a5, 5'd14, 1'b0, '0},
		'{OP_PUSH_FRONT, 32'sh00000001, 5'd1,  1'b1, '{ST_FULL,  32'sd0, 1'b1, 5'd16}},
		'{OP_PUSH_BACK,  32'sh00000002, 5'd1,  1'b1, '{ST_FULL,  32'sd0, 1'b1, 5'd16}},
		'{OP_LIST,       32'sh00000000, 5'd1,  1'b0, '0},
		'{OP_POP_BACK,   32'sh00000000, 5'd8,  1'b0, '0},
		'{OP_POP_FRONT,  32'sh00000000, 5'd8,  1'b0, '0},
		'{OP_PUSH_FRONT, 32'sh5a5a5a5a, 5'd16, 1'b0, '0},
		'{OP_LIST,       32'sh00000000, 5'd1,  1'b0, '0},
		'{OP_POP_FRONT,  32'sh00000000, 5'd15, 1'b0, '0},
		'{OP_LIST,       32'sh00000000, 5'd1,  1'b0, '0},
		'{OP_POP_BACK,   32'sh00000000, 5'd1,  1'b1, '{ST_OK,    32'sd0, 1'b1, 5'd0}}
	};

	double_ended_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.value     (value),
		.strobe    (strobe),
		.status    (status),
		.element   (element),
		.is_last   (is_last),
		.occupancy (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ring model: updates state and queues the words one command produces
	function automatic void deque_apply(input logic [OP_W-1:0] op,
		input logic signed [DW-1:0] val);
		deq_word_t  w;
		logic [3:0] pos;
		w = '0;
		w.is_last = 1'b1;
		case (op)
		OP_PUSH_FRONT, OP_PUSH_BACK: begin
			if (ring_count == CAP) begin
				w.status = ST_FULL;
			end else begin
				if (op == OP_PUSH_FRONT) begin
					ring_head = ring_head - 4'd1;
					ring_mem[ring_head] = val;
				end else begin
					pos = ring_head + ring_count[3:0];
					ring_mem[pos] = val;
				end
				ring_count = ring_count + 5'd1;
				w.status = ST_OK;
			end
		end
		OP_POP_FRONT, OP_POP_BACK: begin
			if (ring_count == 0) begin
				w.status = ST_EMPTY;
			end else begin
				if (op == OP_POP_FRONT)
					ring_head = ring_head + 4'd1;
				ring_count = ring_count - 5'd1;
				w.status = ST_OK;
			end
		end
		OP_LIST: begin
			if (ring_count == 0) begin
				w.status = ST_EMPTY;
			end else begin
				for (int i = 0; i < ring_count; i++) begin
					pos = ring_head + 4'(i);
					w.status = ST_ITEM;
					w.element = ring_mem[pos];
					w.is_last = (i + 1 == ring_count);
					w.occupancy = ring_count;
					pending_words.push_back(w);
				end
				return;
			end
		end
		default: return;
		endcase
		w.occupancy = ring_count;
		pending_words.push_back(w);
	endfunction

	task automatic compare_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch expected %0d actual %0d", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		deq_word_t e;
		if (arst_n) begin
			if (strobe) begin
				if (pending_words.size() == 0) begin
					$display("%0t: unexpected word expected none actual status %0d element %0d",
						$time, status, element);
					mismatch_count++;
				end else begin
					e = pending_words.pop_front();
					compare_field("status", e.status, status);
					compare_field("element", e.element, element);
					compare_field("is_last", e.is_last, is_last);
					compare_field("occupancy", e.occupancy, occupancy);
				end
			end
			if (start && !busy) begin
				deque_apply(opcode, value);
				if (pin_valid && pending_words.size() > 0)
					pending_words[pending_words.size() - 1] = pin_word;
			end
		end
	end

	task automatic send_word(input logic [OP_W-1:0] op, input logic signed [DW-1:0] val,
		input logic pv, input deq_word_t pw);
		start <= 1'b1;
		opcode <= op;
		value <= val;
		pin_valid <= pv;
		pin_word <= pw;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic idle_burst(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic signed [DW-1:0] draw_value();
		case ($urandom_range(0, 7))
		0: return 32'sh7fffffff;
		1: return 32'sh80000000;
		2: return 32'sh00000000;
		3: return 32'shffffffff;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_op(input logic fill);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) begin
			case ($urandom_range(0, 2))
			0: return OP_RSVD_5;
			1: return OP_RSVD_6;
			default: return OP_RSVD_7;
			endcase
		end
		if (r < 16)
			return OP_LIST;
		if (r < (fill ? 70 : 35))
			return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
	endfunction

	initial begin
		int              valid_sent;
		logic            fill;
		logic            drained;
		logic [OP_W-1:0] op;
		valid_sent = 0;
		fill = 1'b1;
		drained = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			for (int k = 0; k < dir_tab[r].rep; k++) begin
				send_word(dir_tab[r].op, dir_tab[r].val ^ k, dir_tab[r].pinned, dir_tab[r].word);
				if ($urandom_range(0, 3) == 0)
					idle_burst($urandom_range(1, 12));
			end
		end

		while (valid_sent < RAND_ITEMS) begin
			op = pick_op(fill);
			send_word(op, draw_value(), 1'b0, '0);
			if (op <= OP_LIST) begin
				valid_sent++;
				if (valid_sent % 25 == 0)
					fill = ~fill;
			end
			if (!drained && valid_sent == RAND_ITEMS / 2) begin
				drained = 1'b1;
				start <= 1'b0;
				do @(posedge clk); while (pending_words.size() != 0);
			end else if (valid_sent < RAND_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
				idle_burst($urandom_range(1, 12));
			end
		end
		start <= 1'b0;

		do @(posedge clk); while (pending_words.size() != 0);
		repeat (24) @(posedge clk);
		if (mismatch_count == 0)
			$display("double_ended_queue_unit verification clean");
		else
			$display("double_ended_queue_unit verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("double_ended_queue_unit verification failed");
		$finish;
	end

endmodule
`default_nettype wire
